// ===== hw/rtl/csvm_pkg.sv =====
// ----------------------------------------------------------------------------
// csvm_pkg: shared types and constants for the sparse matrix-vector block
// Word codes, the command word passed from the front end to the back end,
// queue sizing and configuration register indexes.
// ----------------------------------------------------------------------------
package csvm_pkg;

  // Word kinds, same encoding as the kind field on the input channel
  typedef enum logic [1:0] {
    OP_LOAD_V = 2'd0,
    OP_LOAD_X = 2'd1,
    OP_TERM   = 2'd2,
    OP_EMPTY  = 2'd3
  } csvm_op_t;

  localparam int ADDR_W  = 12;
  localparam int VIDX_W  = 10;
  localparam int DATA_W  = 32;
  localparam int ACC_W   = 64;
  localparam int ROW_W   = 16;
  localparam int END_W   = 17;

  // Command word: va/xa are the value table and x vector addresses (write
  // address for loads, read address for terms). ok clears when a lookup
  // falls outside a store; loads with ok clear never reach the queue.
  typedef struct packed {
    csvm_op_t          op;
    logic [ADDR_W-1:0] va;
    logic [ADDR_W-1:0] xa;
    logic [DATA_W-1:0] data;
    logic              eor;
    logic              ok;
  } csvm_cmd_t;

  localparam int QDEPTH = 4;
  localparam int QPW    = 2;
  localparam int QCW    = 3;

  // Configuration register indexes (word address bit 2)
  localparam logic REG_FIRST_ROW = 1'b0;
  localparam logic REG_END_ROW   = 1'b1;

endpackage

// ===== hw/rtl/csvm_front.sv =====
// ----------------------------------------------------------------------------
// csvm_front: input stage
// Take words from the input channel, classify them into commands, drop loads
// that fall outside their store and push the rest into the command queue.
// ----------------------------------------------------------------------------
module csvm_front #(
  parameter int VALUE_DEPTH  = 1024,
  parameter int VECTOR_DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_kind,
  input  logic [11:0]              in_address,
  input  logic signed [31:0]       in_load_data,
  input  logic [11:0]              in_column,
  input  logic [9:0]               in_value_index,
  input  logic                     in_end_of_row,
  input  logic                     q_full,
  output logic                     q_push,
  output csvm_pkg::csvm_cmd_t      q_data
);
  import csvm_pkg::*;

  logic      hold_v_r;
  csvm_cmd_t hold_r;
  csvm_cmd_t cmd;
  logic      keep;
  logic      leave;
  logic      v_in;
  logic      x_in;

  assign v_in = 32'(in_value_index) < 32'(VALUE_DEPTH);
  assign x_in = 32'(in_column) < 32'(VECTOR_DEPTH);

  always_comb begin
    cmd      = '0;
    cmd.op   = csvm_op_t'(in_kind);
    cmd.data = in_load_data;
    cmd.eor  = in_end_of_row;
    case (cmd.op)
      OP_LOAD_V: begin
        cmd.va = in_address;
        cmd.xa = in_address;
        cmd.ok = 32'(in_address) < 32'(VALUE_DEPTH);
      end
      OP_LOAD_X: begin
        cmd.va = in_address;
        cmd.xa = in_address;
        cmd.ok = 32'(in_address) < 32'(VECTOR_DEPTH);
      end
      OP_TERM: begin
        cmd.va = ADDR_W'(in_value_index);
        cmd.xa = in_column;
        cmd.ok = v_in && x_in;
      end
      default: begin
        cmd.ok = 1'b1;
      end
    endcase
  end

  // Drop out-of-range loads here; they change nothing downstream
  assign keep     = hold_r.ok || hold_r.op == OP_TERM || hold_r.op == OP_EMPTY;
  assign q_push   = hold_v_r && keep && !q_full;
  assign leave    = hold_v_r && (!keep || !q_full);
  assign in_ready = !hold_v_r || leave;
  assign q_data   = hold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_v_r <= 1'b1;
    end else if (leave) begin
      hold_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_r <= cmd;
    end
  end

endmodule

// ===== hw/rtl/csvm_queue.sv =====
// ----------------------------------------------------------------------------
// csvm_queue: command queue
// Short first-in first-out buffer that decouples the front end from the
// back end.
// ----------------------------------------------------------------------------
module csvm_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  csvm_pkg::csvm_cmd_t push_data,
  output logic                full,
  input  logic                pop,
  output logic                not_empty,
  output csvm_pkg::csvm_cmd_t pop_data
);
  import csvm_pkg::*;

  csvm_cmd_t        slot_r [QDEPTH];
  logic [QPW-1:0]   wr_ptr_r;
  logic [QPW-1:0]   rd_ptr_r;
  logic [QCW-1:0]   count_r;
  logic [QCW-1:0]   count_nxt;

  assign full      = count_r == QCW'(QDEPTH);
  assign not_empty = count_r != '0;
  assign pop_data  = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/csvm_back.sv =====
// ----------------------------------------------------------------------------
// csvm_back: execution pipeline
// Three stages: table and vector memory access, multiply, then saturating
// accumulate into the row sum, which also loads the output register.
// ----------------------------------------------------------------------------
module csvm_back #(
  parameter int              VALUE_DEPTH  = 1024,
  parameter int              VECTOR_DEPTH = 4096,
  parameter longint unsigned ROW_LIMIT    = 65536
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  csvm_pkg::csvm_cmd_t q_data,
  output logic                q_pop,
  input  logic [15:0]         first_row,
  input  logic [16:0]         end_row,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [15:0]         out_row_index,
  output logic signed [63:0]  out_row_sum,
  output logic                out_final_row
);
  import csvm_pkg::*;

  localparam int VIW = $clog2(VALUE_DEPTH);
  localparam int XIW = $clog2(VECTOR_DEPTH);
  localparam logic signed [ACC_W-1:0] SAT_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  logic [DATA_W-1:0] vmem [VALUE_DEPTH];
  logic [DATA_W-1:0] xmem [VECTOR_DEPTH];

  logic              adv;
  logic [31:0]       va_ext;
  logic [31:0]       xa_ext;
  logic [VIW-1:0]    va_idx;
  logic [XIW-1:0]    xa_idx;

  // stage 1: memory read
  logic              s1_v_r;
  csvm_op_t          s1_op_r;
  logic              s1_eor_r;
  logic              s1_ok_r;
  logic signed [DATA_W-1:0] v_rd_r;
  logic signed [DATA_W-1:0] x_rd_r;
  logic signed [ACC_W-1:0]  mul_full;

  // stage 2: product
  logic              s2_v_r;
  csvm_op_t          s2_op_r;
  logic              s2_eor_r;
  logic signed [ACC_W-1:0] s2_prod_r;

  // stage 3: accumulate and emit
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_nxt;
  logic signed [ACC_W:0]   sum_wide;
  logic signed [ACC_W-1:0] sum_sat;
  logic [ROW_W-1:0]  rows_r;
  logic [ROW_W-1:0]  rows_nxt;
  logic [ROW_W:0]    rows_inc;
  logic [ROW_W-1:0]  row_idx;
  logic              emit;
  logic              out_valid_r;
  logic [ROW_W-1:0]  out_row_index_r;
  logic signed [ACC_W-1:0] out_row_sum_r;
  logic              out_final_row_r;

  // Advance the whole pipeline unless a result sits unclaimed
  assign adv    = !out_valid_r || out_ready;
  assign q_pop  = adv && q_valid;
  assign va_ext = 32'(q_data.va);
  assign xa_ext = 32'(q_data.xa);
  assign va_idx = va_ext[VIW-1:0];
  assign xa_idx = xa_ext[XIW-1:0];

  always_ff @(posedge clk) begin
    if (q_pop) begin
      if (q_data.op == OP_LOAD_V) vmem[va_idx] <= q_data.data;
      v_rd_r <= vmem[va_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      if (q_data.op == OP_LOAD_X) xmem[xa_idx] <= q_data.data;
      x_rd_r <= xmem[xa_idx];
    end
  end

  // Exact signed Q16.16 x Q16.16 product in Q32.32
  assign mul_full = v_rd_r * x_rd_r;

  // Saturating add of the product into the running sum
  assign sum_wide = {acc_r[ACC_W-1], acc_r} + {s2_prod_r[ACC_W-1], s2_prod_r};
  always_comb begin
    if (sum_wide[ACC_W] != sum_wide[ACC_W-1]) begin
      sum_sat = sum_wide[ACC_W] ? SAT_MIN : SAT_MAX;
    end else begin
      sum_sat = sum_wide[ACC_W-1:0];
    end
  end

  assign emit = s2_v_r && (s2_op_r == OP_EMPTY || (s2_op_r == OP_TERM && s2_eor_r));

  always_comb begin
    acc_nxt = acc_r;
    if (s2_v_r && s2_op_r == OP_TERM) begin
      acc_nxt = s2_eor_r ? '0 : sum_sat;
    end else if (s2_v_r && s2_op_r == OP_EMPTY) begin
      acc_nxt = '0;
    end
  end

  // Wrap the row count at the row limit or at the 16-bit range
  assign rows_inc = {1'b0, rows_r} + 1'b1;
  always_comb begin
    if (rows_inc[ROW_W] || 64'(rows_inc) >= ROW_LIMIT) begin
      rows_nxt = '0;
    end else begin
      rows_nxt = rows_inc[ROW_W-1:0];
    end
  end

  assign row_idx = first_row + rows_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      rows_r      <= '0;
    end else if (adv) begin
      s1_v_r      <= q_valid;
      s2_v_r      <= s1_v_r;
      out_valid_r <= emit;
      acc_r       <= acc_nxt;
      if (emit) rows_r <= rows_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op_r   <= q_data.op;
      s1_eor_r  <= q_data.eor;
      s1_ok_r   <= q_data.ok;
      s2_op_r   <= s1_op_r;
      s2_eor_r  <= s1_eor_r;
      s2_prod_r <= s1_ok_r ? mul_full : '0;
      if (emit) begin
        out_row_index_r <= row_idx;
        out_row_sum_r   <= (s2_op_r == OP_EMPTY) ? '0 : sum_sat;
        out_final_row_r <= (({1'b0, row_idx}) + 1'b1) == end_row;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_row_index = out_row_index_r;
  assign out_row_sum   = out_row_sum_r;
  assign out_final_row = out_final_row_r;

endmodule

// ===== hw/rtl/csvm_core.sv =====
// ----------------------------------------------------------------------------
// csvm_core: front end, command queue and back end joined together
// Connects the input classifier to the execution pipeline through the queue.
// ----------------------------------------------------------------------------
module csvm_core #(
  parameter int              VALUE_DEPTH  = 1024,
  parameter int              VECTOR_DEPTH = 4096,
  parameter longint unsigned ROW_LIMIT    = 65536
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_kind,
  input  logic [11:0]        in_address,
  input  logic signed [31:0] in_load_data,
  input  logic [11:0]        in_column,
  input  logic [9:0]         in_value_index,
  input  logic               in_end_of_row,
  input  logic [15:0]        first_row,
  input  logic [16:0]        end_row,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        out_row_index,
  output logic signed [63:0] out_row_sum,
  output logic               out_final_row
);
  import csvm_pkg::*;

  logic      q_full;
  logic      q_push;
  logic      q_pop;
  logic      q_valid;
  csvm_cmd_t q_wdata;
  csvm_cmd_t q_rdata;

  csvm_front #(
    .VALUE_DEPTH  (VALUE_DEPTH),
    .VECTOR_DEPTH (VECTOR_DEPTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_address     (in_address),
    .in_load_data   (in_load_data),
    .in_column      (in_column),
    .in_value_index (in_value_index),
    .in_end_of_row  (in_end_of_row),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_wdata)
  );

  csvm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_rdata)
  );

  csvm_back #(
    .VALUE_DEPTH  (VALUE_DEPTH),
    .VECTOR_DEPTH (VECTOR_DEPTH),
    .ROW_LIMIT    (ROW_LIMIT)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_data        (q_rdata),
    .q_pop         (q_pop),
    .first_row     (first_row),
    .end_row       (end_row),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_row_index (out_row_index),
    .out_row_sum   (out_row_sum),
    .out_final_row (out_final_row)
  );

endmodule

// ===== hw/rtl/csr_vi_sparse_matvec.sv =====
// ----------------------------------------------------------------------------
// csr_vi_sparse_matvec: value-indexed CSR sparse matrix times dense vector
// Loads fill a unique-value table and the x vector (Q16.16); nonzero words
// multiply a table value by x[column] into a saturating Q32.32 row sum, and
// row-end or empty-row words emit one result with its row number.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake          | Carries
//  ---------+-----------+--------------------+------------------------------------
//  in_*     | input     | in_valid/in_ready  | kind, address, load_data, column,
//           |           |                    | value_index, end_of_row
//  out_*    | output    | out_valid/out_ready| row_index, row_sum, final_row
//  APB      | input     | psel/penable/pready| first_row @0x0, end_row @0x4
//
//  Throughput: one word per cycle sustained while out_ready holds; the single
//  32x32 multiplier and the accumulate loop each take one word per cycle.
//  Path: input register, queue (4 words), memory read, multiply, then the
//  accumulate stage loads the output register and raises out_valid for the
//  word that closes the row.
//  Reset: synchronous, active low; clears the row sum, row count, queue and
//  valid flags. Table and vector contents are undefined until loaded.
//  Stalls: a held result stops the back end only; the queue keeps taking
//  words until it fills, then in_ready drops.
//
module csr_vi_sparse_matvec #(
  parameter int              VALUE_DEPTH  = 1024,
  parameter int              VECTOR_DEPTH = 4096,
  parameter longint unsigned ROW_LIMIT    = 65536
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_kind,
  input  logic [11:0]        in_address,
  input  logic signed [31:0] in_load_data,
  input  logic [11:0]        in_column,
  input  logic [9:0]         in_value_index,
  input  logic               in_end_of_row,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        out_row_index,
  output logic signed [63:0] out_row_sum,
  output logic               out_final_row,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import csvm_pkg::*;

  logic [ROW_W-1:0] first_row_r;
  logic [END_W-1:0] end_row_r;
  logic             cfg_wr;
  logic             reg_sel;

  // Registers sit on word boundaries; bit 2 picks the register
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_row_r <= '0;
      end_row_r   <= 17'h10000;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_FIRST_ROW: first_row_r <= pwdata[ROW_W-1:0];
        REG_END_ROW:   end_row_r   <= pwdata[END_W-1:0];
        default:       first_row_r <= first_row_r;
      endcase
    end
  end

  // Read back the addressed register, zero-extended
  always_comb begin
    case (reg_sel)
      REG_FIRST_ROW: prdata = 32'(first_row_r);
      REG_END_ROW:   prdata = 32'(end_row_r);
      default:       prdata = '0;
    endcase
  end

  csvm_core #(
    .VALUE_DEPTH  (VALUE_DEPTH),
    .VECTOR_DEPTH (VECTOR_DEPTH),
    .ROW_LIMIT    (ROW_LIMIT)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_address     (in_address),
    .in_load_data   (in_load_data),
    .in_column      (in_column),
    .in_value_index (in_value_index),
    .in_end_of_row  (in_end_of_row),
    .first_row      (first_row_r),
    .end_row        (end_row_r),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_row_index  (out_row_index),
    .out_row_sum    (out_row_sum),
    .out_final_row  (out_final_row)
  );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for csr_vi_sparse_matvec
// Loads the value table and x vector, streams nonzero and empty-row words,
// and predicts every row result with an in-bench Q16.16 x Q16.16 -> Q32.32
// saturating accumulator. A directed table runs first, then random phases
// with different register settings and idle/stall patterns on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import csvm_pkg::*;

  localparam int V_DEPTH = 1024;
  localparam int X_DEPTH = 4096;

  // One word on the input channel.
  typedef struct packed {
    csvm_op_t          kind;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic [ADDR_W-1:0] col;
    logic [VIDX_W-1:0] vidx;
    logic              eor;
  } word_t;

  // One word on the result channel.
  typedef struct packed {
    logic [ROW_W-1:0] idx;
    logic [ACC_W-1:0] sum;
    logic             fin;
  } row_result_t;

  // One line of the directed table: the word, and optionally a hand-typed result.
  typedef struct packed {
    word_t       w;
    logic        typed;
    row_result_t r;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                in_valid;
  logic                in_ready;
  logic [1:0]          in_kind;
  logic [11:0]         in_address;
  logic signed [31:0]  in_load_data;
  logic [11:0]         in_column;
  logic [9:0]          in_value_index;
  logic                in_end_of_row;

  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [15:0]         out_row_index;
  logic signed [63:0]  out_row_sum;
  logic                out_final_row;

  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [2:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  // Predictor state: a private copy of the block's stores, row sum and row count.
  logic signed [DATA_W-1:0] vals_q16 [V_DEPTH];
  logic signed [DATA_W-1:0] xvec_q16 [X_DEPTH];
  bit                       v_set [V_DEPTH];
  bit                       x_set [X_DEPTH];
  int                       v_list [$];   // value entries that hold data
  int                       x_list [$];   // x entries that hold data
  longint                   row_acc;
  logic [ROW_W-1:0]         rows_seen;
  logic [ROW_W-1:0]         cfg_first_row;
  logic [END_W-1:0]         cfg_end_row;

  row_result_t rows_due [$];   // row results predicted but not yet seen
  dir_row_t    dir_table [$];
  int          bad_rows;
  int          gap_pct;
  int          stall_pct;

  csr_vi_sparse_matvec DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_address     (in_address),
    .in_load_data   (in_load_data),
    .in_column      (in_column),
    .in_value_index (in_value_index),
    .in_end_of_row  (in_end_of_row),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_row_index  (out_row_index),
    .out_row_sum    (out_row_sum),
    .out_final_row  (out_final_row),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #1 clk = ~clk;

  // Close the current row: number it, flag the last row, restart the sum.
  function automatic row_result_t close_row(input longint sum);
    row_result_t r;
    r.idx = cfg_first_row + rows_seen;
    r.sum = sum;
    r.fin = ({1'b0, r.idx} + 17'd1) == cfg_end_row;
    rows_seen = rows_seen + 1'b1;   // 16-bit count wraps at 2^16, the row limit
    row_acc = 0;
    return r;
  endfunction

  // Apply one accepted word to the predictor; return 1 when it yields a row.
  function automatic bit spmv_word(input word_t w, output row_result_t r);
    longint prod;
    longint acc_next;
    r = '0;
    case (w.kind)
      OP_LOAD_V: begin
        // Out-of-range addresses write nothing.
        if (w.addr < V_DEPTH) begin
          if (!v_set[w.addr]) v_list.push_back(int'(w.addr));
          v_set[w.addr] = 1'b1;
          vals_q16[w.addr] = w.data;
        end
        return 1'b0;
      end
      OP_LOAD_X: begin
        if (w.addr < X_DEPTH) begin
          if (!x_set[w.addr]) x_list.push_back(int'(w.addr));
          x_set[w.addr] = 1'b1;
          xvec_q16[w.addr] = w.data;
        end
        return 1'b0;
      end
      OP_TERM: begin
        // Exact Q32.32 product, then a saturating add.
        prod = longint'(vals_q16[w.vidx]) * longint'(xvec_q16[w.col]);
        acc_next = row_acc + prod;
        if (row_acc > 0 && prod > 0 && acc_next < 0)
          acc_next = 64'h7FFF_FFFF_FFFF_FFFF;
        else if (row_acc < 0 && prod < 0 && acc_next >= 0)
          acc_next = 64'h8000_0000_0000_0000;
        row_acc = acc_next;
        if (!w.eor) return 1'b0;
        r = close_row(row_acc);
        return 1'b1;
      end
      default: begin
        // Empty row: zero sum, any partial sum is dropped.
        r = close_row(0);
        return 1'b1;
      end
    endcase
  endfunction

  // Drive one word and hold it until the block takes it. Sample in_ready at
  // the falling edge; it comes from registers only and holds until the rise.
  task automatic send_word(input word_t w);
    logic took;
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_valid       <= 1'b1;
    in_kind        <= w.kind;
    in_address     <= w.addr;
    in_load_data   <= w.data;
    in_column      <= w.col;
    in_value_index <= w.vidx;
    in_end_of_row  <= w.eor;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
  endtask

  task automatic issue(input word_t w);
    row_result_t r;
    send_word(w);
    if (spmv_word(w, r)) rows_due.push_back(r);
  endtask

  // Register write: setup phase, then access phase.
  task automatic cfg_write(input logic reg_sel, input logic [31:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_sel == REG_FIRST_ROW) cfg_first_row = value[ROW_W-1:0];
    else cfg_end_row = value[END_W-1:0];
  endtask

  // Drop valid, drain all due rows, then let loads and open terms clear the pipe.
  task automatic settle();
    in_valid <= 1'b0;
    while (rows_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  function automatic word_t rand_word(input csvm_op_t k);
    word_t w;
    w.kind = k;
    w.addr = ADDR_W'($urandom);
    w.data = $urandom;
    w.col  = ADDR_W'($urandom);
    w.vidx = VIDX_W'($urandom);
    w.eor  = 1'($urandom);
    return w;
  endfunction

  // Nonzero that reads only entries that were loaded.
  function automatic word_t term_word(input bit last);
    word_t w;
    w = rand_word(OP_TERM);
    w.vidx = VIDX_W'(v_list[$urandom_range(0, v_list.size() - 1)]);
    w.col  = ADDR_W'(x_list[$urandom_range(0, x_list.size() - 1)]);
    w.eor  = last;
    return w;
  endfunction

  task automatic dir_add(input csvm_op_t k, input int a, input logic [31:0] d,
                         input int c, input int vi, input bit e, input bit t,
                         input int ri, input logic [63:0] rs, input bit rf);
    dir_row_t row;
    row.w.kind = k;
    row.w.addr = ADDR_W'(a);
    row.w.data = d;
    row.w.col  = ADDR_W'(c);
    row.w.vidx = VIDX_W'(vi);
    row.w.eor  = e;
    row.typed  = t;
    row.r.idx  = ROW_W'(ri);
    row.r.sum  = rs;
    row.r.fin  = rf;
    dir_table.push_back(row);
  endtask

  // Mostly complete rows with random content; some loads, empty rows and
  // rows cut short by an empty-row word.
  task automatic random_phase(input int quota);
    int    sent;
    int    pick;
    int    n;
    word_t w;
    sent = 0;
    while (sent < quota) begin
      pick = $urandom_range(99);
      if (pick < 66) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 5);
        for (int k = 0; k < n; k++) issue(term_word(k == n - 1));
        sent += n;
      end else if (pick < 76) begin
        issue(rand_word(OP_EMPTY));
        sent++;
      end else if (pick < 92) begin
        w = rand_word(($urandom_range(1) != 0) ? OP_LOAD_X : OP_LOAD_V);
        if (w.kind == OP_LOAD_V && $urandom_range(3) != 0)
          w.addr = ADDR_W'($urandom_range(0, V_DEPTH - 1));
        if ($urandom_range(1) != 0) w.data = $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
        issue(w);
        // an out-of-range table load is ignored by the block and not counted
        if (!(w.kind == OP_LOAD_V && w.addr >= V_DEPTH)) sent++;
      end else begin
        n = $urandom_range(1, 3);
        for (int k = 0; k < n; k++) issue(term_word(1'b0));
        issue(rand_word(OP_EMPTY));
        sent += n + 1;
      end
    end
  endtask

  // Result side: at the falling edge, check each word that the next rising
  // edge accepts; the outputs and out_ready hold steady until then.
  always @(negedge clk) begin : row_check
    row_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (rows_due.size() == 0) begin
        bad_rows++;
        if (bad_rows <= 10)
          $display("unexpected row: idx %0d sum %h final %b",
                   out_row_index, out_row_sum, out_final_row);
      end else begin
        want = rows_due.pop_front();
        if (out_row_index !== want.idx || out_row_sum !== want.sum ||
            out_final_row !== want.fin) begin
          bad_rows++;
          if (bad_rows <= 10)
            $display("row mismatch: got idx %0d sum %h final %b, want idx %0d sum %h final %b",
                     out_row_index, out_row_sum, out_final_row,
                     want.idx, want.sum, want.fin);
        end
      end
    end
  end

  // Pick next cycle's ready at the rising edge.
  always @(posedge clk) begin : ready_drive
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin : stimulus
    row_result_t      r;
    logic [ROW_W-1:0] fr;
    logic [ROW_W-1:0] hit;
    logic [END_W-1:0] er;

    bad_rows       = 0;
    gap_pct        = 0;
    stall_pct      = 0;
    row_acc        = 0;
    rows_seen      = '0;
    cfg_first_row  = '0;
    cfg_end_row    = 17'h10000;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_kind        <= OP_LOAD_V;
    in_address     <= '0;
    in_load_data   <= '0;
    in_column      <= '0;
    in_value_index <= '0;
    in_end_of_row  <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;

    // Directed table, reset register values: first row 0, no final row.
    //        kind       addr  data           col   vidx eor typed row sum            fin
    dir_add(OP_LOAD_V, 1023, 32'h8000_0000, 0,    0,    0, 0, 0, 64'h0, 0);
    dir_add(OP_LOAD_V, 0,    32'h7FFF_FFFF, 0,    0,    0, 0, 0, 64'h0, 0);
    dir_add(OP_LOAD_X, 4095, 32'h8000_0000, 0,    0,    0, 0, 0, 64'h0, 0);
    dir_add(OP_LOAD_X, 0,    32'h7FFF_FFFF, 0,    0,    0, 0, 0, 64'h0, 0);
    // table loads past the table's end must not alias onto entries 0 and 1023
    dir_add(OP_LOAD_V, 1024, 32'hDEAD_BEEF, 0,    0,    0, 0, 0, 64'h0, 0);
    dir_add(OP_LOAD_V, 4095, 32'h5555_AAAA, 0,    0,    0, 0, 0, 64'h0, 0);
    // empty row right after reset
    dir_add(OP_EMPTY,  4095, 32'hFFFF_FFFF, 4095, 1023, 1, 1, 0, 64'h0, 0);
    // (-1<<31)^2 twice: clamp at the positive limit
    dir_add(OP_TERM,   0,    32'h0,         4095, 1023, 0, 0, 0, 64'h0, 0);
    dir_add(OP_TERM,   0,    32'h0,         4095, 1023, 1, 1, 1,
            64'h7FFF_FFFF_FFFF_FFFF, 0);
    // max * min three times: clamp at the negative limit
    dir_add(OP_TERM,   0,    32'h0,         4095, 0,    0, 0, 0, 64'h0, 0);
    dir_add(OP_TERM,   0,    32'h0,         4095, 0,    0, 0, 0, 64'h0, 0);
    dir_add(OP_TERM,   0,    32'h0,         4095, 0,    1, 1, 2,
            64'h8000_0000_0000_0000, 0);
    // clamp high, then a negative term pulls the sum back
    dir_add(OP_TERM,   0,    32'h0,         4095, 1023, 0, 0, 0, 64'h0, 0);
    dir_add(OP_TERM,   0,    32'h0,         4095, 1023, 0, 0, 0, 64'h0, 0);
    dir_add(OP_TERM,   0,    32'h0,         4095, 0,    1, 0, 0, 64'h0, 0);
    // empty row drops an open partial sum
    dir_add(OP_TERM,   0,    32'h0,         0,    0,    0, 0, 0, 64'h0, 0);
    dir_add(OP_EMPTY,  0,    32'h0,         0,    0,    0, 1, 4, 64'h0, 0);
    dir_add(OP_TERM,   0,    32'h0,         0,    0,    1, 0, 0, 64'h0, 0);
    // zero x element, then small Q16.16 values: 1.0 * -2.0
    dir_add(OP_LOAD_X, 1,    32'h0,         0,    0,    0, 0, 0, 64'h0, 0);
    dir_add(OP_TERM,   0,    32'h0,         1,    1023, 1, 0, 0, 64'h0, 0);
    dir_add(OP_LOAD_V, 2,    32'h0001_0000, 0,    0,    0, 0, 0, 64'h0, 0);
    dir_add(OP_LOAD_X, 2,    32'hFFFE_0000, 0,    0,    0, 0, 0, 64'h0, 0);
    dir_add(OP_TERM,   0,    32'h0,         2,    2,    1, 0, 0, 64'h0, 0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the table; typed rows take their hand-written result, the rest
    // take the predictor's. The predictor runs on every row to keep state.
    foreach (dir_table[i]) begin
      send_word(dir_table[i].w);
      if (spmv_word(dir_table[i].w, r))
        rows_due.push_back(dir_table[i].typed ? dir_table[i].r : r);
    end

    // Random phases: each one changes both registers while idle and uses
    // one of four idle/stall patterns, in turn.
    for (int p = 0; p < 8; p++) begin
      settle();
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 78; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 78; end
        default: begin gap_pct = 33; stall_pct = 33; end
      endcase
      case (p)
        0: fr = 16'h0000;
        1: fr = 16'hFFFF;
        // start a few rows short of 65535 so the row number wraps
        2: fr = 16'hFFFB - rows_seen;
        default: fr = ROW_W'($urandom_range(0, 65535));
      endcase
      hit = fr + rows_seen + ROW_W'($urandom_range(3, 40));
      case (p)
        1: er = 17'h00000;             // no row is ever final
        2: er = 17'h10000;             // final exactly at row 65535
        default: er = {1'b0, hit} + 17'd1;
      endcase
      cfg_write(REG_FIRST_ROW, {16'h0, fr});
      cfg_write(REG_END_ROW, {15'h0, er});
      random_phase(212);
    end

    settle();
    if (bad_rows == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Hard stop far beyond the slowest correct run.
  initial begin : watchdog
    #1_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== csr_vi_sparse_matvec.f =====
hw/rtl/csvm_pkg.sv
hw/rtl/csvm_front.sv
hw/rtl/csvm_queue.sv
hw/rtl/csvm_back.sv
hw/rtl/csvm_core.sv
hw/rtl/csr_vi_sparse_matvec.sv
tb/testbench.sv
